// ----- rtl/core/window_kurtosis_defines.svh -----
// Assertion macros shared by the window kurtosis RTL.
// Depends on nothing; the asserting file supplies clock and reset by name.
`ifndef WINDOW_KURTOSIS_DEFINES_SVH
`define WINDOW_KURTOSIS_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define WK_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("window_kurtosis: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define WK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("window_kurtosis: next-cycle check failed");
`else
`define WK_ASSERT_SAME(label, ante, cons)
`define WK_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/wk_pkg.sv -----
// Shared types and constants of the window kurtosis block.
// Depends on nothing; used by every module of the block.
package wk_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int VALUE_W           = 27;
   localparam int COUNT_OUT_W       = 11;
   localparam int REQ_DATA_W        = 16;
   localparam int RSP_DATA_W        = 40;
   localparam int DEF_MAX_SAMPLES   = 1024;
   localparam int DEF_FRACTION_BITS = 16;

   // Sequencer states of the window pass.
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_READ,
      ST_CENTER,
      ST_SQUARE,
      ST_FOURTH,
      ST_CHECK,
      ST_NUMER,
      ST_DENOM,
      ST_DIVIDE,
      ST_OUTPUT
   } wk_state_type;

endpackage

// ----- rtl/core/wk_store.sv -----
// Sample memory of one window: one write port, one registered read port.
// Depends on wk_pkg for the sample width.
module wk_store
   import wk_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_SAMPLES
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [SAMPLE_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [SAMPLE_W-1:0] rd_data
);

   logic signed [SAMPLE_W-1:0] store_ff [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/wk_mul.sv -----
// Shared shift-add multiplier: one multiplier bit per cycle, stops early.
// Depends on wk_pkg only through the common import convention.
module wk_mul
   import wk_pkg::*;
#(
   parameter int PW = 130,
   parameter int BW = 65
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [PW-1:0] op_a,
   input  logic [BW-1:0] op_b,
   output logic          done,
   output logic [PW-1:0] product
);

   logic          busy_ff, busy_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] a_ff, a_in;
   logic [BW-1:0] b_ff, b_in;

   // The product is complete once every set multiplier bit is consumed.
   assign done    = busy_ff && (b_ff == '0);
   assign product = acc_ff;

   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            acc_in = b_ff[0] ? acc_ff + a_ff : acc_ff;
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

endmodule

// ----- rtl/core/wk_div.sv -----
// Restoring divider: one quotient bit per cycle, most significant first.
// Depends on wk_pkg only through the common import convention.
module wk_div
   import wk_pkg::*;
#(
   parameter int NW   = 146,
   parameter int DENW = 130,
   parameter int QW   = 27
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NW-1:0]   numer,
   input  logic [DENW-1:0] denom,
   output logic            done,
   output logic [QW-1:0]   quotient
);

   localparam int XW   = (NW > DENW + QW - 1) ? NW : DENW + QW - 1;
   localparam int CNTW = $clog2(QW + 1);

   logic            busy_ff, busy_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [XW-1:0]   rem_ff, rem_in;
   logic [XW-1:0]   dsh_ff, dsh_in;
   logic [QW-1:0]   q_ff, q_in;
   logic            ge;

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = q_ff;
   assign ge       = rem_ff >= dsh_ff;

   // Compare and subtract the shifted divisor, then move it one bit down.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(QW);
         rem_in  = XW'(numer);
         dsh_in  = XW'(denom) << (QW - 1);
         q_in    = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            rem_in = ge ? rem_ff - dsh_ff : rem_ff;
            q_in   = {q_ff[QW-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

endmodule

// ----- rtl/core/window_kurtosis.sv -----
// Window kurtosis: samples are taken one word per cycle and stored; the word
// marked last, or the one that fills MAX_SAMPLES, closes the window and the
// block stops taking words while it makes a second pass. That pass runs on one
// shared shift-add multiplier, which handles one multiplier bit per cycle and
// forms d^2 and then d^4 for each stored sample, with d = n*x - sum. When the
// variance is not zero, the close then adds two more products, n*sum(d^4) and
// sum(d^2)^2, and a quotient from the restoring divider. The result is
// n*sum(d^4)/sum(d^2)^2 in unsigned Q.16, or 2.0 with flat set when the
// variance is zero.
`include "window_kurtosis_defines.svh"

module window_kurtosis
   import wk_pkg::*;
#(
   parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] sample
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [26:0] kurtosis_value, [37:27] sample_count
   output logic                  rsp_tuser   // [0] flat
);

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int SW   = SAMPLE_W + CW;
   localparam int MW   = SAMPLE_W + CW;
   localparam int DDW  = MW + 1;
   localparam int S2W  = 2 * MW + CW;
   localparam int S4W  = 4 * MW + CW;
   localparam int PW   = 4 * MW + 2 * CW;
   localparam int BW   = S2W;
   localparam int NW   = PW + FRACTION_BITS;
   localparam int QW   = CW + FRACTION_BITS;
   localparam int QXW  = QW + VALUE_W;
   localparam int PADW = RSP_DATA_W - VALUE_W - COUNT_OUT_W;
   localparam logic [CW-1:0]      MAX_COUNT  = CW'(MAX_SAMPLES);
   localparam logic [VALUE_W-1:0] FLAT_VALUE = VALUE_W'(2) << FRACTION_BITS;
   localparam logic [QXW-1:0]     VALUE_MAX  = QXW'({VALUE_W{1'b1}});

   wk_state_type state_ff, state_in;

   logic [CW-1:0]            count_ff, count_in;
   logic signed [SW-1:0]     sum_ff, sum_in;
   logic [CW-1:0]            n_ff, n_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [S2W-1:0]           sum2_ff, sum2_in;
   logic [S4W-1:0]           sum4_ff, sum4_in;
   logic [PW-1:0]            num_ff, num_in;
   logic [VALUE_W-1:0]       res_value_ff, res_value_in;
   logic                     res_flat_ff, res_flat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                     rsp_flat_ff, rsp_flat_in;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                     req_accept;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                     wr_en;
   logic signed [SAMPLE_W-1:0] rd_sample;
   logic signed [DDW-1:0]    nx;
   logic signed [DDW-1:0]    dev;
   logic [MW-1:0]            mag;
   logic                     mul_start, mul_done;
   logic [PW-1:0]            mul_a, mul_prod;
   logic [BW-1:0]            mul_b;
   logic                     div_start, div_done;
   logic [QW-1:0]            div_q;
   logic [QXW-1:0]           q_ext;
   logic [VALUE_W-1:0]       q_sat;

   assign req_sample = $signed(req_tdata[SAMPLE_W-1:0]);
   assign req_tready = (state_ff == ST_LOAD);
   assign req_accept = req_tvalid && req_tready;

   // Sample memory.
   wk_store #(
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_sample),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_sample)
   );

   // Shared multiplier for d^2, d^4, n*sum(d^4) and sum(d^2)^2.
   wk_mul #(
      .PW (PW),
      .BW (BW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Final division; the numerator carries the fraction bits.
   wk_div #(
      .NW   (NW),
      .DENW (PW),
      .QW   (QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    ({num_ff, {FRACTION_BITS{1'b0}}}),
      .denom    (mul_prod),
      .done     (div_done),
      .quotient (div_q)
   );

   // Centered value of the sample just read, scaled by n, and its magnitude.
   assign nx  = DDW'($signed({1'b0, n_ff})) * DDW'(rd_sample);
   assign dev = nx - DDW'(sum_ff);
   assign mag = dev[DDW-1] ? MW'(-dev) : MW'(dev);

   // Saturate the quotient to the output field.
   assign q_ext = QXW'(div_q);
   assign q_sat = (q_ext > VALUE_MAX) ? VALUE_W'(VALUE_MAX) : q_ext[VALUE_W-1:0];

   // Sequencer: load, pass over the window, products, division, output.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      sum2_in      = sum2_ff;
      sum4_in      = sum4_ff;
      num_in       = num_ff;
      res_value_in = res_value_ff;
      res_flat_in  = res_flat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_flat_in  = rsp_flat_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               sum_in   = sum_ff + SW'(req_sample);
               if (req_tlast || (count_ff + 1'b1 == MAX_COUNT)) begin
                  n_in     = count_ff + 1'b1;
                  idx_in   = '0;
                  sum2_in  = '0;
                  sum4_in  = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CENTER;
         end
         ST_CENTER: begin
            mul_start = 1'b1;
            mul_a     = PW'(mag);
            mul_b     = BW'(mag);
            state_in  = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (mul_done) begin
               sum2_in   = sum2_ff + S2W'(mul_prod);
               mul_start = 1'b1;
               mul_a     = mul_prod;
               mul_b     = BW'(mul_prod);
               state_in  = ST_FOURTH;
            end
         end
         ST_FOURTH: begin
            if (mul_done) begin
               sum4_in = sum4_ff + S4W'(mul_prod);
               idx_in  = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == n_ff) begin
                  state_in = ST_CHECK;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_CHECK: begin
            if (sum2_ff == '0) begin
               res_value_in = FLAT_VALUE;
               res_flat_in  = 1'b1;
               state_in     = ST_OUTPUT;
            end else begin
               mul_start = 1'b1;
               mul_a     = PW'(sum4_ff);
               mul_b     = BW'(n_ff);
               state_in  = ST_NUMER;
            end
         end
         ST_NUMER: begin
            if (mul_done) begin
               num_in    = mul_prod;
               mul_start = 1'b1;
               mul_a     = PW'(sum2_ff);
               mul_b     = sum2_ff;
               state_in  = ST_DENOM;
            end
         end
         ST_DENOM: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               res_value_in = q_sat;
               res_flat_in  = 1'b0;
               state_in     = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_flat_in  = res_flat_ff;
               rsp_count_in = COUNT_OUT_W'(n_ff);
               count_in     = '0;
               sum_in       = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      sum2_ff      <= sum2_in;
      sum4_ff      <= sum4_in;
      num_ff       <= num_in;
      res_value_ff <= res_value_in;
      res_flat_ff  <= res_flat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flat_ff  <= rsp_flat_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PADW{1'b0}}, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_flat_ff;

   // A closing word stops intake; it resumes once the result is in the output register.
   `WK_ASSERT_NEXT(a_close_stalls, req_accept && req_tlast, !req_tready)
   // The open window never holds a full store while words are taken.
   `WK_ASSERT_SAME(a_count_bound, state_ff == ST_LOAD, count_ff < MAX_COUNT)
   // The multiplier is idle whenever samples are being loaded.
   `WK_ASSERT_SAME(a_mul_idle_load, state_ff == ST_LOAD, !mul_done)
   // A flat result always carries the value 2.0.
   `WK_ASSERT_SAME(a_flat_value, rsp_valid_ff && rsp_flat_ff, rsp_value_ff == FLAT_VALUE)

endmodule

// ----- test/window_kurtosis_checker.sv -----
// Checker for window_kurtosis: watches both stream channels, predicts each window's kurtosis
// and compares every result word. Depends on wk_pkg and on the port packing of the block.
`timescale 1ns / 100ps

module window_kurtosis_checker
   import wk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] sample
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // [26:0] kurtosis_value, [37:27] sample_count
   input  logic                  rsp_tuser,  // [0] flat
   output int                    error_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [VALUE_W-1:0]     value;
      logic                   flat;
      logic [COUNT_OUT_W-1:0] count;
   } kurtosis_result_type;

   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   logic signed [SAMPLE_W-1:0] window_samples [DEF_MAX_SAMPLES];
   int                         window_len;
   longint                     window_sum;
   kurtosis_result_type        expected_results [$];

   // Second pass over the stored window, exact in 256-bit arithmetic.
   function automatic kurtosis_result_type measure_window(int n);
      kurtosis_result_type r;
      logic [255:0]     sum_sq, sum_quad, sq, mag, numer, denom, quot;
      longint           d;
      sum_sq   = '0;
      sum_quad = '0;
      for (int i = 0; i < n; i++) begin
         d = longint'(n) * longint'(window_samples[i]) - window_sum;
         mag = (d < 0) ? 256'(-d) : 256'(d);
         sq = mag * mag;
         sum_sq   += sq;
         sum_quad += sq * sq;
      end
      r.count = n[COUNT_OUT_W-1:0];
      if (sum_sq == 0) begin
         r.flat  = 1'b1;
         r.value = VALUE_W'(2) << DEF_FRACTION_BITS;
      end else begin
         r.flat = 1'b0;
         numer  = (sum_quad * 256'(n)) << DEF_FRACTION_BITS;
         denom  = sum_sq * sum_sq;
         quot   = numer / denom;
         r.value = (quot > 256'(VALUE_MAX)) ? VALUE_MAX : quot[VALUE_W-1:0];
      end
      return r;
   endfunction

   assign pending_count = expected_results.size();

   // Predict on every accepted input word, compare on every accepted result word.
   always @(posedge clock) begin
      kurtosis_result_type want;
      kurtosis_result_type got;
      if (reset) begin
         window_len  = 0;
         window_sum  = 0;
         error_count <= 0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            window_samples[window_len] = req_tdata[SAMPLE_W-1:0];
            window_len = window_len + 1;
            window_sum = window_sum + longint'($signed(req_tdata[SAMPLE_W-1:0]));
            if (req_tlast || window_len == DEF_MAX_SAMPLES) begin
               expected_results.push_back(measure_window(window_len));
               window_len = 0;
               window_sum = 0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[VALUE_W-1:0];
            got.count = rsp_tdata[VALUE_W +: COUNT_OUT_W];
            got.flat  = rsp_tuser;
            if (expected_results.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected result word value=%0d flat=%0b count=%0d",
                           $realtime, got.value, got.flat, got.count);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got != want) begin
                  if (error_count < 10)
                     $display("%0t: expected value=%0d flat=%0b count=%0d, got %0d %0b %0d",
                              $realtime, want.value, want.flat, want.count,
                              got.value, got.flat, got.count);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- test/testbench.sv -----
// Top of the window_kurtosis testbench: clock, reset, stimulus and the verdict.
// Depends on wk_pkg, the window_kurtosis RTL and window_kurtosis_checker.
`timescale 1ns / 100ps

module testbench;
   import wk_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // [15:0] sample
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [26:0] kurtosis_value, [37:27] sample_count
   logic                  rsp_tuser;       // [0] flat
   int                    error_count;
   int                    pending_count;
   logic                  sender_busy = 1'b1;  // high while the sender draws idle gaps
   logic                  receiver_busy = 1'b1;
   logic                  receiver_hold = 1'b0;

   window_kurtosis dut (.*);

   window_kurtosis_checker checker_inst (.*);

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit, well above the slowest correct run.
   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // Offer one word, after an optional idle gap, and wait for its handshake.
   task automatic send_sample(logic signed [SAMPLE_W-1:0] sample, logic last);
      int gap;
      gap = sender_busy ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // One window of n samples drawn by flavor; the final one is marked last if mark_last is set.
   task automatic send_window(int n, int flavor, logic mark_last);
      logic signed [SAMPLE_W-1:0] base, s;
      base = SAMPLE_W'($urandom);
      for (int i = 0; i < n; i++) begin
         case (flavor)
            0: s = SAMPLE_W'($urandom);
            1: s = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
            2: s = base;
            default: s = ($urandom_range(0, 9) == 0) ? SAMPLE_W'($urandom)
                                                     : SAMPLE_W'($urandom_range(0, 3));
         endcase
         send_sample(s, mark_last && (i == n - 1));
      end
   endtask

   // Receiver: random stalls, one long hold-off on request.
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (receiver_hold) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(negedge clock);
            receiver_hold = 1'b0;
         end
         gap = receiver_busy ? $urandom_range(0, 19) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Stimulus.
   initial begin
      int n;
      int drain;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: one-sample window, constant windows, extremes, a heavy tail.
      send_sample(16'sh7fff, 1'b1);
      send_window(3, 2, 1'b1);
      send_sample(-16'sd32768, 1'b0);
      send_sample(-16'sd32768, 1'b1);
      send_sample(16'sh7fff, 1'b0);
      send_sample(-16'sd32768, 1'b1);
      send_sample(-16'sd32768, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shaaaa, 1'b0);
      send_sample(16'sd0, 1'b1);
      for (int i = 0; i < 10; i++) send_sample((i == 4) ? 16'sh7fff : 16'sd0, i == 9);

      // Sender pauses until every expected result is back.
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);

      // Long receiver hold-off while the sender keeps offering.
      receiver_hold = 1'b1;
      for (int w = 0; w < 6; w++) send_window($urandom_range(1, 4), 0, 1'b1);

      // A window that fills up without a last mark, then one more sample.
      send_window(DEF_MAX_SAMPLES, 0, 1'b0);
      send_sample(SAMPLE_W'($urandom), 1'b1);

      // Random windows, mostly short, with stretches of no idling.
      for (int w = 0; w < 55; w++) begin
         sender_busy   = ($urandom_range(0, 3) != 0);
         receiver_busy = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       n = 1;
            1:       n = $urandom_range(20, 40);
            default: n = $urandom_range(2, 10);
         endcase
         send_window(n, $urandom_range(0, 3), 1'b1);
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      // Drain, then allow a short settle time.
      drain = 0;
      while (pending_count != 0 && drain < 400000) begin
         @(negedge clock);
         drain++;
      end
      repeat (200) @(negedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
